@@ hw/rtl/ritoa_pkg.sv @@
// ============================================================================
// Radix integer-to-ASCII package
// Shared widths, transaction types and the digit-to-glyph mapping for the
// radix integer-to-ASCII converter.
// ============================================================================
package ritoa_pkg;

    // Field widths of the transactions.
    localparam int NUMBER_W = 64;
    localparam int RADIX_W  = 6;
    localparam int CHAR_W   = 7;

    // Number of low bits of the input value that take part in the conversion.
    localparam int VALUE_WIDTH = 64;

    // Digit storage.
    localparam int DIGIT_W     = 6;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;

    // Long division retires DIV_STEPS quotient bits per cycle.
    localparam int DIV_STEPS  = 8;
    localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PAD_WIDTH  = DIV_CYCLES * DIV_STEPS;
    localparam int STEP_W     = $clog2(DIV_CYCLES + 1);

    // Valid bases and glyph constants.
    localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] DIGIT_SPAN = RADIX_W'(10 + 26);
    localparam logic [RADIX_W-1:0] DEC_SPAN   = RADIX_W'(10);
    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0]  CHAR_LC_A  = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0]  CHAR_LC_Z  = CHAR_W'(8'h7a);

    typedef struct packed {
        logic [NUMBER_W-1:0] number;
        logic [RADIX_W-1:0]  radix;
    } t_in_item;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              error;
    } t_out_item;

    // Maps a digit value to its lower-case ASCII glyph.
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] g;
        if (d < DEC_SPAN) begin
            g = CHAR_ZERO + CHAR_W'(d);
        end else if (d < DIGIT_SPAN) begin
            g = CHAR_LC_A + CHAR_W'(d - DEC_SPAN);
        end else begin
            g = '0;
        end
        return g;
    endfunction

endpackage

@@ hw/rtl/radix_integer_to_ascii_core.sv @@
// ============================================================================
// Radix integer-to-ASCII converter core
// Converts an unsigned value into ASCII digits of a base from 2 to 36 and
// emits them most significant first, one character per output transaction.
// ============================================================================
// Timing: each digit of a nonzero value takes a full pass of the padded value through
// the divider, which retires eight quotient bits per cycle. Each character is read from
// the digit store in S_RD and registered into the output in S_WAIT.
// Input: the next input is stalled until the last character, or the error transaction
// for an invalid base, has been issued; receiver stalls hold the core in S_RD or S_ERR.
// Reset is synchronous, active low, and clears the control state but not the memory.
module radix_integer_to_ascii_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ritoa_pkg::t_in_item   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ritoa_pkg::t_out_item  o_out
);
    import ritoa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ERR  = 5'b00010,
        S_DIV  = 5'b00100,
        S_RD   = 5'b01000,
        S_WAIT = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic [PAD_WIDTH-1:0] r_val, n_val;
    logic [DIGIT_W-1:0]   r_rem, n_rem;
    logic [RADIX_W-1:0]   r_radix, n_radix;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [COUNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]    r_ptr, n_ptr;
    t_out_item            r_out, n_out;
    logic                 r_out_vld, n_out_vld;
    logic [DIGIT_W-1:0]   r_rd_data;

    logic [DIGIT_W-1:0]   mem [STORE_DEPTH];
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_wa;
    logic [DIGIT_W-1:0]   mem_wd;
    logic                 rd_en;

    logic [PAD_WIDTH-1:0] div_val;
    logic [DIGIT_W-1:0]   div_rem;
    logic                 out_free;
    logic                 radix_ok;
    logic [VALUE_WIDTH-1:0] in_value;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    assign out_free = !r_out_vld || !i_out_stall;
    assign radix_ok = (i_in.radix >= RADIX_MIN) && (i_in.radix <= DIGIT_SPAN);
    assign in_value = i_in.number[VALUE_WIDTH-1:0];

    // Restoring long division: each step shifts one dividend bit into the
    // remainder and shifts the quotient bit into the bottom of the same word.
    always_comb begin
        logic [PAD_WIDTH-1:0] v;
        logic [DIGIT_W:0]     t;
        logic [DIGIT_W-1:0]   rm;
        v  = r_val;
        rm = r_rem;
        for (int i = 0; i < DIV_STEPS; i++) begin
            t = {rm, v[PAD_WIDTH-1]};
            v = {v[PAD_WIDTH-2:0], 1'b0};
            if (t >= {1'b0, r_radix}) begin
                t    = t - {1'b0, r_radix};
                v[0] = 1'b1;
            end
            rm = t[DIGIT_W-1:0];
        end
        div_val = v;
        div_rem = rm;
    end

    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_rem     = r_rem;
        n_radix   = r_radix;
        n_step    = r_step;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_out     = r_out;
        n_out_vld = r_out_vld;
        mem_we    = 1'b0;
        mem_wa    = r_count[ADDR_W-1:0];
        mem_wd    = div_rem;
        rd_en     = 1'b0;

        if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (!radix_ok) begin
                        n_state = S_ERR;
                    end else begin
                        n_radix = i_in.radix;
                        n_val   = PAD_WIDTH'(in_value);
                        n_rem   = '0;
                        n_step  = '0;
                        if (in_value == '0) begin
                            // A zero value is the single digit zero.
                            mem_we  = 1'b1;
                            mem_wa  = '0;
                            mem_wd  = '0;
                            n_count = COUNT_W'(1);
                            n_ptr   = '0;
                            n_state = S_RD;
                        end else begin
                            n_count = '0;
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_out.character = '0;
                    n_out.last      = 1'b1;
                    n_out.error     = 1'b1;
                    n_out_vld       = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_DIV: begin
                n_val  = div_val;
                n_rem  = div_rem;
                n_step = r_step + 1'b1;
                if (r_step == STEP_W'(DIV_CYCLES - 1)) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_count[ADDR_W-1:0];
                    mem_wd  = div_rem;
                    n_count = r_count + 1'b1;
                    n_rem   = '0;
                    n_step  = '0;
                    if ((div_val == '0) || (r_count == COUNT_W'(STORE_DEPTH - 1))) begin
                        n_ptr   = r_count[ADDR_W-1:0];
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                // Issue the read only when the output register is free at
                // the edge where the character lands.
                if (out_free) begin
                    rd_en   = 1'b1;
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_out.character = digit_glyph(r_rd_data);
                n_out.last      = (r_ptr == '0);
                n_out.error     = 1'b0;
                n_out_vld       = 1'b1;
                if (r_ptr == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_count   <= '0;
            r_step    <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_count   <= n_count;
            r_step    <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_rem   <= n_rem;
        r_radix <= n_radix;
        r_ptr   <= n_ptr;
        r_out   <= n_out;
    end

    // The partial remainder always stays below the base.
    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_radix))
        else $error("partial remainder not below radix");

    // The digit count never exceeds the store depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(STORE_DEPTH))
        else $error("digit count beyond store depth");

    // Emission only reads entries written during the current item.
    a_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_WAIT)) |-> (COUNT_W'(r_ptr) < r_count))
        else $error("read pointer outside collected digits");

    // An error transaction is a lone, empty, final character.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.error) |-> (r_out.last && (r_out.character == '0)))
        else $error("malformed error transaction");

    // A character that is not an error is a valid digit glyph.
    a_glyph_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out.error) |->
            (r_out.character >= CHAR_ZERO) && (r_out.character <= CHAR_LC_Z))
        else $error("character outside digit glyphs");

endmodule
